FILE: rtl/cpct_pkg.sv
// ----------------------------------------------------------------------------
// cpct_pkg: shared types and constants
// Request and result payloads, table entry layout, commands and sequencer states.
// ----------------------------------------------------------------------------
package cpct_pkg;

  localparam int DEF_MAX_ENTRIES = 8;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // result queue; also bounds the number of pair tests in flight
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_MOVE   = 2'd2;
  localparam logic [1:0] MODE_SWEEP  = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         handle;
    logic               is_circle;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] first_handle;
    logic [7:0] second_handle;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         handle;
    logic               is_circle;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        radius;
  } entry_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_MOVE,
    OP_SWEEP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         handle;
    logic               is_circle;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        radius;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [7:0] first_handle;
    logic [7:0] second_handle;
  } hit_t;

  typedef struct packed {
    logic                 full;
    logic [RES_CNT_W-1:0] count;
  } res_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/cpct_ram.sv
// ----------------------------------------------------------------------------
// cpct_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cpct_ram #(
  parameter int WIDTH = $bits(cpct_pkg::entry_t),
  parameter int DEPTH = cpct_pkg::DEF_MAX_ENTRIES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/cpct_front.sv
// ----------------------------------------------------------------------------
// cpct_front: request intake
// Accepts requests, decodes the mode into a command and queues it for the back.
// ----------------------------------------------------------------------------
module cpct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  cpct_pkg::in_item_t item,
  output logic               cmd_valid,
  output cpct_pkg::cmd_t     cmd,
  input  logic               cmd_take
);

  cpct_pkg::cmd_t                 q [cpct_pkg::CMD_DEPTH];
  logic [cpct_pkg::CMD_PTR_W-1:0] wp;
  logic [cpct_pkg::CMD_PTR_W-1:0] rp;
  logic [cpct_pkg::CMD_CNT_W-1:0] cnt;
  cpct_pkg::cmd_t                 decoded;
  logic                           wr;

  always_comb begin
    decoded.handle    = item.handle;
    decoded.is_circle = item.is_circle;
    decoded.x_pos     = item.x_pos;
    decoded.y_pos     = item.y_pos;
    decoded.radius    = item.radius;
    case (item.mode)
      cpct_pkg::MODE_ADD:    decoded.op = cpct_pkg::OP_ADD;
      cpct_pkg::MODE_REMOVE: decoded.op = cpct_pkg::OP_REMOVE;
      cpct_pkg::MODE_MOVE:   decoded.op = cpct_pkg::OP_MOVE;
      cpct_pkg::MODE_SWEEP:  decoded.op = cpct_pkg::OP_SWEEP;
      default:               decoded.op = cpct_pkg::OP_SWEEP;
    endcase
  end

  assign full      = (cnt == cpct_pkg::CMD_CNT_W'(cpct_pkg::CMD_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rp];
  assign wr        = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + cpct_pkg::CMD_PTR_W'(1);
      end
      if (cmd_take) begin
        rp <= rp + cpct_pkg::CMD_PTR_W'(1);
      end
      cnt <= cnt + cpct_pkg::CMD_CNT_W'(wr) - cpct_pkg::CMD_CNT_W'(cmd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= decoded;
    end
  end

endmodule

FILE: rtl/cpct_pair_unit.sv
// ----------------------------------------------------------------------------
// cpct_pair_unit: pair overlap test
// Three-stage pipeline: differences, squares, sum and compare.
// ----------------------------------------------------------------------------
module cpct_pair_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  cpct_pkg::entry_t a,
  input  cpct_pkg::entry_t b,
  output cpct_pkg::hit_t   hit
);

  // stage 1
  logic               v1;
  logic               both1;
  logic signed [16:0] dx1;
  logic signed [16:0] dy1;
  logic [15:0]        rs1;
  logic [7:0]         ha1;
  logic [7:0]         hb1;
  // stage 2
  logic               v2;
  logic               both2;
  logic [31:0]        dx2;
  logic [31:0]        dy2;
  logic [31:0]        rs2;
  logic [7:0]         ha2;
  logic [7:0]         hb2;
  // stage 3
  logic               v3;
  logic               hit3;
  logic [7:0]         ha3;
  logic [7:0]         hb3;

  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic [31:0]        rs_sq;
  logic [32:0]        dist_sq;

  assign dx_sq   = dx1 * dx1;
  assign dy_sq   = dy1 * dy1;
  assign rs_sq   = rs1 * rs1;
  assign dist_sq = {1'b0, dx2} + {1'b0, dy2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    both1 <= a.is_circle & b.is_circle;
    dx1   <= {a.x_pos[15], a.x_pos} - {b.x_pos[15], b.x_pos};
    dy1   <= {a.y_pos[15], a.y_pos} - {b.y_pos[15], b.y_pos};
    rs1   <= {1'b0, a.radius} + {1'b0, b.radius};
    ha1   <= a.handle;
    hb1   <= b.handle;

    // squares of 17-bit differences stay below 2^32
    both2 <= both1;
    dx2   <= dx_sq[31:0];
    dy2   <= dy_sq[31:0];
    rs2   <= rs_sq;
    ha2   <= ha1;
    hb2   <= hb1;

    hit3  <= both2 && (dist_sq <= {1'b0, rs2});
    ha3   <= ha2;
    hb3   <= hb2;
  end

  assign hit.valid         = v3;
  assign hit.hit           = hit3;
  assign hit.first_handle  = ha3;
  assign hit.second_handle = hb3;

endmodule

FILE: rtl/cpct_res_q.sv
// ----------------------------------------------------------------------------
// cpct_res_q: result queue
// Small FIFO in flops holding results until they are popped.
// ----------------------------------------------------------------------------
module cpct_res_q (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  cpct_pkg::out_item_t   wdata,
  output cpct_pkg::res_status_t status,
  input  logic                  pop,
  output logic                  empty,
  output cpct_pkg::out_item_t   head
);

  cpct_pkg::out_item_t            q [cpct_pkg::RES_DEPTH];
  logic [cpct_pkg::RES_PTR_W-1:0] wp;
  logic [cpct_pkg::RES_PTR_W-1:0] rp;
  logic [cpct_pkg::RES_CNT_W-1:0] cnt;
  logic                           rd;

  assign empty        = (cnt == '0);
  assign head         = q[rp];
  assign rd           = pop && !empty;
  assign status.count = cnt;
  assign status.full  = (cnt == cpct_pkg::RES_CNT_W'(cpct_pkg::RES_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + cpct_pkg::RES_PTR_W'(1);
      end
      if (rd) begin
        rp <= rp + cpct_pkg::RES_PTR_W'(1);
      end
      cnt <= cnt + cpct_pkg::RES_CNT_W'(wr) - cpct_pkg::RES_CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= wdata;
    end
  end

endmodule

FILE: rtl/cpct_back.sv
// ----------------------------------------------------------------------------
// cpct_back: command execution
// Sequencer over the entry RAM: append, compacting remove, move, pair sweep.
// ----------------------------------------------------------------------------
module cpct_back #(
  parameter int MAX_ENTRIES = cpct_pkg::DEF_MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cpct_pkg::cmd_t        cmd,
  output logic                  cmd_take,
  output logic                  res_push,
  output cpct_pkg::out_item_t   res_data,
  input  cpct_pkg::res_status_t res_stat
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CRED_W = cpct_pkg::RES_CNT_W + 1;

  cpct_pkg::state_t               state;
  cpct_pkg::state_t               state_next;
  cpct_pkg::cmd_t                 cur;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               rd_idx;
  logic [CNT_W-1:0]               wr_idx;
  logic [IDX_W-1:0]               scan_idx;
  logic                           scan_v;
  logic [CNT_W-1:0]               si;
  logic [CNT_W-1:0]               sj;
  logic                           pair_v;
  logic [cpct_pkg::RES_CNT_W-1:0] inflight;
  logic                           pend_v;
  logic [7:0]                     pend_first;
  logic [7:0]                     pend_second;
  logic [1:0]                     resp_kind;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  cpct_pkg::entry_t               ram_wdata;
  logic [IDX_W-1:0]               raddr_a;
  logic [IDX_W-1:0]               raddr_b;
  logic [$bits(cpct_pkg::entry_t)-1:0] rdata_a;
  logic [$bits(cpct_pkg::entry_t)-1:0] rdata_b;
  cpct_pkg::entry_t               ent_a;
  cpct_pkg::entry_t               ent_b;
  cpct_pkg::entry_t               cur_entry;
  cpct_pkg::entry_t               moved;
  cpct_pkg::hit_t                 hit;

  logic                           room;
  logic                           scan_issue;
  logic                           scan_done;
  logic                           rm_keep;
  logic                           pair_issue;
  logic                           last_pair;
  logic                           credit_ok;

  cpct_ram #(
    .WIDTH ($bits(cpct_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  cpct_pair_unit u_pair (
    .clk   (clk),
    .rst   (rst),
    .valid (pair_v),
    .a     (ent_a),
    .b     (ent_b),
    .hit   (hit)
  );

  assign ent_a = cpct_pkg::entry_t'(rdata_a);
  assign ent_b = cpct_pkg::entry_t'(rdata_b);

  assign cur_entry.handle    = cur.handle;
  assign cur_entry.is_circle = cur.is_circle;
  assign cur_entry.x_pos     = cur.x_pos;
  assign cur_entry.y_pos     = cur.y_pos;
  assign cur_entry.radius    = cur.radius;

  // move keeps handle and circle flag
  assign moved.handle    = ent_a.handle;
  assign moved.is_circle = ent_a.is_circle;
  assign moved.x_pos     = cur.x_pos;
  assign moved.y_pos     = cur.y_pos;
  assign moved.radius    = cur.radius;

  assign room      = (count < CNT_W'(MAX_ENTRIES));
  assign scan_done = (rd_idx == count) && !scan_v;
  assign last_pair = (si == count - CNT_W'(2)) && (sj == count - CNT_W'(1));
  // every pair in flight may push one result; never overrun the result queue
  assign credit_ok = ({1'b0, res_stat.count} + {1'b0, inflight})
                     < CRED_W'(cpct_pkg::RES_DEPTH);

  always_comb begin
    state_next = state;
    case (state)
      cpct_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            cpct_pkg::OP_ADD:    state_next = cpct_pkg::ST_ADD;
            cpct_pkg::OP_REMOVE: state_next = cpct_pkg::ST_SCAN;
            cpct_pkg::OP_MOVE:   state_next = cpct_pkg::ST_SCAN;
            cpct_pkg::OP_SWEEP: begin
              state_next = (count < CNT_W'(2)) ? cpct_pkg::ST_FINISH : cpct_pkg::ST_SWEEP;
            end
            default:             state_next = cpct_pkg::ST_IDLE;
          endcase
        end
      end
      cpct_pkg::ST_ADD:    state_next = cpct_pkg::ST_RESP;
      cpct_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = cpct_pkg::ST_RESP;
        end
      end
      cpct_pkg::ST_SWEEP: begin
        if (pair_issue && last_pair) begin
          state_next = cpct_pkg::ST_DRAIN;
        end
      end
      cpct_pkg::ST_DRAIN: begin
        if (inflight == '0) begin
          state_next = cpct_pkg::ST_FINISH;
        end
      end
      cpct_pkg::ST_FINISH: begin
        if (!res_stat.full) begin
          state_next = cpct_pkg::ST_IDLE;
        end
      end
      cpct_pkg::ST_RESP: begin
        if (!res_stat.full) begin
          state_next = cpct_pkg::ST_IDLE;
        end
      end
      default: state_next = cpct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take               = 1'b0;
    ram_we                 = 1'b0;
    ram_waddr              = '0;
    ram_wdata              = cur_entry;
    raddr_a                = '0;
    raddr_b                = '0;
    scan_issue             = 1'b0;
    rm_keep                = 1'b0;
    pair_issue             = 1'b0;
    res_push               = 1'b0;
    res_data.result_kind   = cpct_pkg::KIND_ACK;
    res_data.first_handle  = '0;
    res_data.second_handle = '0;
    res_data.last          = 1'b1;
    case (state)
      cpct_pkg::ST_IDLE: cmd_take = cmd_valid;
      cpct_pkg::ST_ADD: begin
        ram_we    = room;
        ram_waddr = count[IDX_W-1:0];
      end
      cpct_pkg::ST_SCAN: begin
        scan_issue = (rd_idx < count);
        raddr_a    = rd_idx[IDX_W-1:0];
        if (scan_v) begin
          if (cur.op == cpct_pkg::OP_REMOVE) begin
            // compaction: survivors slide down to the write index
            if (ent_a.handle != cur.handle) begin
              rm_keep   = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = wr_idx[IDX_W-1:0];
              ram_wdata = ent_a;
            end
          end else if (ent_a.handle == cur.handle) begin
            ram_we    = 1'b1;
            ram_waddr = scan_idx;
            ram_wdata = moved;
          end
        end
      end
      cpct_pkg::ST_SWEEP: begin
        pair_issue = credit_ok;
        raddr_a    = si[IDX_W-1:0];
        raddr_b    = sj[IDX_W-1:0];
      end
      cpct_pkg::ST_RESP: begin
        res_push              = !res_stat.full;
        res_data.result_kind  = resp_kind;
        res_data.first_handle = cur.handle;
      end
      cpct_pkg::ST_FINISH: begin
        res_push = !res_stat.full;
        if (pend_v) begin
          res_data.result_kind   = cpct_pkg::KIND_PAIR;
          res_data.first_handle  = pend_first;
          res_data.second_handle = pend_second;
        end else begin
          res_data.result_kind = cpct_pkg::KIND_NONE;
        end
      end
      default: ;
    endcase
    // a new hit releases the one held back; the final one gets last at the end
    if (hit.valid && hit.hit && pend_v) begin
      res_push               = 1'b1;
      res_data.result_kind   = cpct_pkg::KIND_PAIR;
      res_data.first_handle  = pend_first;
      res_data.second_handle = pend_second;
      res_data.last          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cpct_pkg::ST_IDLE;
      count    <= '0;
      scan_v   <= 1'b0;
      pair_v   <= 1'b0;
      inflight <= '0;
      pend_v   <= 1'b0;
    end else begin
      state    <= state_next;
      scan_v   <= scan_issue;
      pair_v   <= pair_issue;
      inflight <= inflight + cpct_pkg::RES_CNT_W'(pair_issue)
                  - cpct_pkg::RES_CNT_W'(hit.valid);
      if (cmd_take) begin
        pend_v <= 1'b0;
      end else if (hit.valid && hit.hit) begin
        pend_v <= 1'b1;
      end
      if (state == cpct_pkg::ST_ADD && room) begin
        count <= count + CNT_W'(1);
      end else if (state == cpct_pkg::ST_SCAN && scan_done &&
                   cur.op == cpct_pkg::OP_REMOVE) begin
        count <= wr_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur       <= cmd;
      rd_idx    <= '0;
      wr_idx    <= '0;
      si        <= '0;
      sj        <= CNT_W'(1);
      resp_kind <= cpct_pkg::KIND_ACK;
    end
    if (state == cpct_pkg::ST_ADD && !room) begin
      resp_kind <= cpct_pkg::KIND_FULL;
    end
    if (scan_issue) begin
      rd_idx   <= rd_idx + CNT_W'(1);
      scan_idx <= rd_idx[IDX_W-1:0];
    end
    if (rm_keep) begin
      wr_idx <= wr_idx + CNT_W'(1);
    end
    if (pair_issue) begin
      if (sj == count - CNT_W'(1)) begin
        si <= si + CNT_W'(1);
        sj <= si + CNT_W'(2);
      end else begin
        sj <= sj + CNT_W'(1);
      end
    end
    if (hit.valid && hit.hit) begin
      pend_first  <= hit.first_handle;
      pend_second <= hit.second_handle;
    end
  end

endmodule

FILE: rtl/circle_pair_collision_table.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_table: circle trigger table with pairwise overlap sweep
// Front queues decoded requests; back edits the entry RAM and sweeps pairs.
// ----------------------------------------------------------------------------
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------
//   request   | push / full          | item   (cpct_pkg::in_item_t)
//   result    | empty / pop          | result (cpct_pkg::out_item_t)
//
// A sweep issues one pair test per cycle into a 3-stage multiply/compare
// pipeline, throttled by the 8-entry result queue. Two requests may wait in
// the front queue while the back is busy.
// Reset clears counters and state only; the entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module circle_pair_collision_table #(
  parameter int MAX_ENTRIES = cpct_pkg::DEF_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  cpct_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output cpct_pkg::out_item_t result
);

  logic                  cmd_valid;
  cpct_pkg::cmd_t        cmd;
  logic                  cmd_take;
  logic                  res_push;
  cpct_pkg::out_item_t   res_data;
  cpct_pkg::res_status_t res_stat;

  cpct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  cpct_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_stat  (res_stat)
  );

  cpct_res_q u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_push),
    .wdata  (res_data),
    .status (res_stat),
    .pop    (pop),
    .empty  (empty),
    .head   (result)
  );

`ifndef SYNTH
  // pair credits must keep the result queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_stat.full)
    else $error("result pushed into full queue");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // one command at a time in the back
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !cmd_take)
    else $error("back took two commands in a row");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.result_kind == cpct_pkg::KIND_PAIR || result.last))
    else $error("single result without last");
`endif

endmodule
